// ----- rtl/pml_pkg.sv -----
// Shared types and constants for the parenthesis mismatch locator.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package pml_pkg;

    localparam int POS_W   = 12;
    localparam int DEPTH_W = 13;
    localparam int KIND_W  = 2;

    localparam logic [7:0] OPEN_CHAR  = 8'h28;
    localparam logic [7:0] CLOSE_CHAR = 8'h29;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 13'd8191;

    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic push;
        logic pop;
    } pml_shift_t;

endpackage

`default_nettype wire

// ----- rtl/pml_if.sv -----
// Valid/ready channel interfaces for the character and result streams.
// Depends on pml_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pml_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

interface pml_out_if;
    logic                        valid;
    logic                        ready;
    logic [pml_pkg::POS_W-1:0]   position;
    logic [pml_pkg::KIND_W-1:0]  kind;
    logic                        overflow;
    logic                        last_of_run;

    modport source (output valid, output position, output kind, output overflow,
                    output last_of_run, input ready);
    modport sink (input valid, input position, input kind, input overflow,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/pml_cell.sv -----
// One entry of the shifting position stack.
// Depends on pml_pkg for the position type and the shift control struct.
`timescale 1ns / 1ps
`default_nettype none

module pml_cell (
    input  wire                 clk,
    input  pml_pkg::pml_shift_t shift,
    input  pml_pkg::pos_t       left_pos,
    input  pml_pkg::pos_t       right_pos,
    output pml_pkg::pos_t       pos
);
    import pml_pkg::*;

    pos_t pos_reg;
    pos_t pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (shift.push)
        begin
            pos_next = left_pos;
        end
        else if (shift.pop)
        begin
            pos_next = right_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

// ----- rtl/paren_mismatch_locator.sv -----
// An unmatched-close result is registered in the cycle after the beat that causes it.
// One character per cycle while the output register is free; after the final character
// a drain emits each stored open, then an end marker, while no character is taken.
// The stack is a row of shifting cells, so a push or a pop moves every cell together.
// Reset clears counters, flags and the output register; stack entries stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module paren_mismatch_locator #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_LEN     = 4096
) (
    input  wire        clk,
    input  wire        rst_n,
    pml_in_if.sink     char_in,
    pml_out_if.source  result_out
);
    import pml_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                ovf_reg, ovf_next;
    logic                out_valid_reg, out_valid_next;
    pos_t                position_reg, position_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                overflow_reg, overflow_next;
    logic                last_reg, last_next;

    pml_shift_t          shift;
    pos_t                new_pos;
    pos_t                cell_pos [STACK_DEPTH];
    logic                slot_free;
    logic                accept;

    assign slot_free     = !out_valid_reg || result_out.ready;
    assign char_in.ready = (state_reg == ST_RUN) && slot_free;
    assign accept        = char_in.valid && char_in.ready;
    assign new_pos       = POS_W'(idx_reg);

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        pos_t left_pos;
        pos_t right_pos;
        if (i == 0)
        begin : g_first
            assign left_pos = new_pos;
        end
        else
        begin : g_mid_left
            assign left_pos = cell_pos[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign right_pos = '0;
        end
        else
        begin : g_mid_right
            assign right_pos = cell_pos[i+1];
        end
        pml_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .left_pos  (left_pos),
            .right_pos (right_pos),
            .pos       (cell_pos[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        depth_next     = depth_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        position_next  = position_reg;
        kind_next      = kind_reg;
        overflow_next  = overflow_reg;
        last_next      = last_reg;
        shift          = '0;

        if (accept)
        begin
            if (char_in.char_code == OPEN_CHAR)
            begin
                if (stored_reg < CNT_W'(STACK_DEPTH))
                begin
                    shift.push  = 1'b1;
                    stored_next = stored_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (depth_reg != DEPTH_MAX)
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            else if (char_in.char_code == CLOSE_CHAR)
            begin
                if (depth_reg != '0)
                begin
                    if (depth_reg <= DEPTH_W'(stored_reg) && stored_reg != '0)
                    begin
                        shift.pop   = 1'b1;
                        stored_next = stored_reg - 1'b1;
                    end
                    depth_next = depth_reg - 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    position_next  = new_pos;
                    kind_next      = KIND_CLOSE;
                    overflow_next  = 1'b0;
                    last_next      = !char_in.end_of_string;
                end
            end

            if (char_in.end_of_string)
            begin
                state_next = ST_DRAIN;
            end
            else if (idx_reg >= IDX_W'(MAX_LEN - 1))
            begin
                idx_next = IDX_W'(MAX_LEN - 1);
                ovf_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (state_reg == ST_DRAIN && slot_free)
        begin
            out_valid_next = 1'b1;
            if (stored_reg != '0)
            begin
                shift.pop     = 1'b1;
                stored_next   = stored_reg - 1'b1;
                position_next = cell_pos[0];
                kind_next     = KIND_OPEN;
                overflow_next = 1'b0;
                last_next     = 1'b0;
            end
            else
            begin
                position_next = '0;
                kind_next     = KIND_END;
                overflow_next = ovf_reg;
                last_next     = 1'b1;
                depth_next    = '0;
                idx_next      = '0;
                ovf_next      = 1'b0;
                state_next    = ST_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            stored_reg    <= '0;
            depth_reg     <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            kind_reg      <= KIND_CLOSE;
            overflow_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            depth_reg     <= depth_next;
            idx_reg       <= idx_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            position_reg  <= position_next;
            kind_reg      <= kind_next;
            overflow_reg  <= overflow_next;
            last_reg      <= last_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.position    = position_reg;
    assign result_out.kind        = kind_reg;
    assign result_out.overflow    = overflow_reg;
    assign result_out.last_of_run = last_reg;

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    a_stored_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        DEPTH_W'(stored_reg) <= depth_reg)
        else $error("more stored opens than open parentheses");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && slot_free && stored_reg == '0)
        |=> (state_reg == ST_RUN && depth_reg == '0 && idx_reg == '0 && !ovf_reg
             && out_valid_reg && kind_reg == KIND_END))
        else $error("end marker did not restore the idle state");

    a_drain_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && slot_free && stored_reg != '0)
        |=> (stored_reg == $past(stored_reg) - 1'b1 && kind_reg == KIND_OPEN))
        else $error("drain step did not pop one stored open");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for paren_mismatch_locator: drives strings over the character channel
// and checks every result beat against a predictor kept inside the testbench.
// Depends on pml_pkg, the pml_in_if/pml_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module tb_top;

    import pml_pkg::*;

    localparam int STACK_SLOTS = 32;
    localparam int MAX_CHARS   = 4096;

    typedef struct {
        pos_t              position;
        logic [KIND_W-1:0] kind;
        logic              overflow;
        logic              last_of_run;
    } mismatch_t;

    logic clk;
    logic rst_n;

    pml_in_if  char_in ();
    pml_out_if result_out ();

    paren_mismatch_locator #(
        .STACK_DEPTH (STACK_SLOTS),
        .MAX_LEN     (MAX_CHARS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .result_out (result_out)
    );

    pos_t        open_stack [STACK_SLOTS];
    int unsigned stored_opens;
    int unsigned open_depth;
    int unsigned char_pos;
    logic        overflow_flag;
    mismatch_t   expected_reports [$];

    bit src_gaps;
    bit sink_gaps;
    int hold_off_cycles;
    int failures;
    int chars_sent;
    int strings_sent;
    int reports_checked;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void note_failure(input string what, input mismatch_t exp_r,
                                         input mismatch_t got_r);
        failures++;
        if (failures <= 10)
        begin
            $write("%0t: %s: expected pos=%0d kind=%0d ovf=%0b last=%0b",
                   $realtime, what, exp_r.position, exp_r.kind, exp_r.overflow,
                   exp_r.last_of_run);
            $display(", got pos=%0d kind=%0d ovf=%0b last=%0b",
                     got_r.position, got_r.kind, got_r.overflow, got_r.last_of_run);
        end
    endfunction

    function automatic void add_report(input pos_t p, input logic [KIND_W-1:0] k,
                                       input logic ovf, input logic last);
        mismatch_t r;
        r.position    = p;
        r.kind        = k;
        r.overflow    = ovf;
        r.last_of_run = last;
        expected_reports = {expected_reports, r};
    endfunction

    function automatic void clear_string_state();
        stored_opens  = 0;
        open_depth    = 0;
        char_pos      = 0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void predict_mismatches(input logic [7:0] code, input logic final_char);
        pos_t here;
        here = pos_t'(char_pos);
        if (code == OPEN_CHAR)
        begin
            if (stored_opens < STACK_SLOTS)
            begin
                open_stack[stored_opens] = here;
                stored_opens++;
            end
            else
                overflow_flag = 1'b1;
            if (open_depth < DEPTH_MAX)
                open_depth++;
        end
        else if (code == CLOSE_CHAR)
        begin
            if (open_depth > 0)
            begin
                if (open_depth <= stored_opens && stored_opens > 0)
                    stored_opens--;
                open_depth--;
            end
            else
                add_report(here, KIND_CLOSE, 1'b0, !final_char);
        end
        if (!final_char)
        begin
            if (char_pos >= MAX_CHARS - 1)
            begin
                char_pos      = MAX_CHARS - 1;
                overflow_flag = 1'b1;
            end
            else
                char_pos++;
            return;
        end
        while (stored_opens > 0)
        begin
            stored_opens--;
            add_report(open_stack[stored_opens], KIND_OPEN, 1'b0, 1'b0);
        end
        add_report('0, KIND_END, overflow_flag, 1'b1);
        clear_string_state();
    endfunction

    always @(posedge clk)
    begin
        mismatch_t got_r;
        mismatch_t exp_r;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            got_r.position    = result_out.position;
            got_r.kind        = result_out.kind;
            got_r.overflow    = result_out.overflow;
            got_r.last_of_run = result_out.last_of_run;
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                exp_r = '{default: 'x};
                note_failure("unexpected result beat", exp_r, got_r);
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                if (got_r.position !== exp_r.position || got_r.kind !== exp_r.kind ||
                    got_r.overflow !== exp_r.overflow ||
                    got_r.last_of_run !== exp_r.last_of_run)
                    note_failure("result mismatch", exp_r, got_r);
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_out.ready <= 1'b0;
            end
            else if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles - 1;
                hold_off_cycles = 0;
                result_out.ready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                result_out.ready <= 1'b0;
            end
            else
                result_out.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] filler_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == OPEN_CHAR || b == CLOSE_CHAR);
        return b;
    endfunction

    task automatic send_char(input logic [7:0] code, input logic final_char);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            char_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_in.valid         <= 1'b1;
        char_in.char_code     <= code;
        char_in.end_of_string <= final_char;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        predict_mismatches(code, final_char);
        chars_sent++;
        if (final_char)
            strings_sent++;
    endtask

    task automatic send_string(input logic [7:0] text [$]);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic test_directed_cases();
        send_string('{8'h00, 8'hFF, CLOSE_CHAR, OPEN_CHAR, 8'h27, OPEN_CHAR, CLOSE_CHAR,
                      8'h2A, OPEN_CHAR, CLOSE_CHAR});
        send_string('{CLOSE_CHAR});
        send_string('{OPEN_CHAR});
        send_string('{8'h80});
        send_string('{OPEN_CHAR, OPEN_CHAR, CLOSE_CHAR, 8'h55, 8'hAA, 8'h7F});
        send_string('{CLOSE_CHAR, CLOSE_CHAR, OPEN_CHAR});
    endtask

    task automatic test_stack_full();
        logic [7:0] text [$];
        repeat (36) text = {text, OPEN_CHAR};
        repeat (5) text = {text, CLOSE_CHAR};
        text = {text, filler_char()};
        send_string(text);
        text.delete();
        repeat (STACK_SLOTS) text = {text, OPEN_CHAR};
        text = {text, CLOSE_CHAR};
        send_string(text);
    endtask

    task automatic test_output_backpressure();
        logic [7:0] text [$];
        repeat (30) text = {text, CLOSE_CHAR};
        text = {text, OPEN_CHAR};
        hold_off_cycles = 80;
        send_string(text);
    endtask

    task automatic test_random_strings(input int n_chars);
        logic [7:0] text [$];
        int start;
        int len;
        int depth;
        int mode;
        int n_open;
        start = chars_sent;
        while (chars_sent - start < n_chars)
        begin
            text.delete();
            depth = 0;
            mode  = $urandom_range(0, 9);
            len   = $urandom_range(1, 24);
            if (mode < 6)
            begin
                for (int i = 0; i < len; i++)
                begin
                    if (depth > 0 && len - i <= depth)
                    begin
                        text = {text, CLOSE_CHAR};
                        depth--;
                    end
                    else
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                text = {text, OPEN_CHAR};
                                depth++;
                            end
                            1:
                            begin
                                if (depth > 0)
                                begin
                                    text = {text, CLOSE_CHAR};
                                    depth--;
                                end
                                else
                                    text = {text, filler_char()};
                            end
                            default: text = {text, filler_char()};
                        endcase
                end
            end
            else if (mode < 8)
            begin
                repeat (len)
                    case ($urandom_range(0, 3))
                        0: text = {text, OPEN_CHAR};
                        1: text = {text, CLOSE_CHAR};
                        default: text = {text, filler_char()};
                    endcase
            end
            else if (mode == 8)
            begin
                n_open = $urandom_range(28, 40);
                repeat (n_open)
                    text = {text, ($urandom_range(0, 3) == 0 ? filler_char() : OPEN_CHAR)};
                repeat ($urandom_range(0, n_open + 3))
                    text = {text, CLOSE_CHAR};
            end
            else
            begin
                repeat (len)
                    text = {text, 8'($urandom_range(0, 255))};
            end
            send_string(text);
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        char_in.valid         <= 1'b0;
        char_in.char_code     <= '0;
        char_in.end_of_string <= 1'b0;
        src_gaps        = 1'b1;
        sink_gaps       = 1'b1;
        hold_off_cycles = 0;
        failures        = 0;
        chars_sent      = 0;
        strings_sent    = 0;
        reports_checked = 0;
        clear_string_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_stack_full();
        test_output_backpressure();
        test_random_strings(130);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_strings(50);

        char_in.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (expected_reports.size() != 0)
            note_failure("expected result never arrived", expected_reports[0],
                         '{default: 'x});

        $display("Sent %0d strings (%0d characters) and checked %0d result beats.",
                 strings_sent, chars_sent, reports_checked);
        $display("Runs included unmatched closes, stack overflow and a long output stall.");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
